@@ src/cnhc_pkg.sv @@
// ============================================================================
// Cascaded notch / high-pass chain: shared package
// Widths, constants, the sequencer state type and the saturation helper.
// ============================================================================
package cnhc_pkg;

    // Number of cascaded notch sections and the sample width.
    localparam int NOTCH_STAGES = 6;
    localparam int SAMPLE_WIDTH = 16;

    // Width of the stage counter, which must be at least one bit wide.
    localparam int STAGE_W = (NOTCH_STAGES > 1) ? $clog2(NOTCH_STAGES) : 1;

    // Q16 coefficient register.
    localparam int COEF_W = 17;
    localparam logic [COEF_W-1:0] COEF_RESET = COEF_W'(87301);

    // Fraction bits of the notch arithmetic.
    localparam int FRAC_BITS = 16;

    // 0.75 * 2^16 is 3 << 14; 0.5 * 2^16 is 1 << 15.
    localparam int FF_SHIFT = FRAC_BITS - 2;
    localparam int FB_SHIFT = FRAC_BITS - 1;

    // Product width: unsigned coefficient times a difference of two samples.
    localparam int PROD_W = COEF_W + 1 + SAMPLE_WIDTH + 1;

    // Accumulator width, with headroom for all three notch terms.
    localparam int ACC_W = COEF_W + SAMPLE_WIDTH + 3;

    // High-pass: (d << 15 + y1 << 10) >> 16 equals (d << 5 + y1) >> 6.
    localparam int HP_GAIN_SHIFT = 5;
    localparam int HP_OUT_SHIFT = 6;
    localparam int HP_W = SAMPLE_WIDTH + HP_GAIN_SHIFT + 2;

    localparam logic signed [ACC_W-1:0] SAT_MAX =
        ACC_W'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1);
    localparam logic signed [ACC_W-1:0] SAT_MIN =
        ACC_W'(-(64'sd1 <<< (SAMPLE_WIDTH - 1)));

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_ACC,
        ST_TAIL
    } seq_state_t;

    typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;

    // Saturate a wide signed value to the sample range.
    function automatic sample_t sat_sample(input logic signed [ACC_W-1:0] v);
        sample_t r;
        if (v > SAT_MAX) begin
            r = SAT_MAX[SAMPLE_WIDTH-1:0];
        end else if (v < SAT_MIN) begin
            r = SAT_MIN[SAMPLE_WIDTH-1:0];
        end else begin
            r = v[SAMPLE_WIDTH-1:0];
        end
        return r;
    endfunction

endpackage

@@ src/cascaded_notch_highpass_chain.sv @@
// ============================================================================
// Cascaded notch / high-pass chain
// A new sample is taken only in the idle state, so the block is through with one
// sample before it takes the next. The one shared multiplier is visited by every
// notch section in a multiply cycle followed by an accumulate cycle, and the
// tail step waits while an unread result is held. Synchronous active-low reset
// clears all filter history, unprimes the averager and reloads the default
// coefficient.
// ============================================================================
module cascaded_notch_highpass_chain (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [cnhc_pkg::COEF_W-1:0]          cfg_wr_data,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [cnhc_pkg::SAMPLE_WIDTH-1:0] s_sample,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [cnhc_pkg::SAMPLE_WIDTH-1:0] m_filtered
);

    localparam int SW = cnhc_pkg::SAMPLE_WIDTH;
    localparam int NS = cnhc_pkg::NOTCH_STAGES;
    localparam int AW = cnhc_pkg::ACC_W;
    localparam int PW = cnhc_pkg::PROD_W;
    localparam int HW = cnhc_pkg::HP_W;

    // Sequencer and datapath registers.
    cnhc_pkg::seq_state_t                 state_reg, state_next;
    logic [cnhc_pkg::STAGE_W-1:0]         stage_reg, stage_next;
    logic [cnhc_pkg::COEF_W-1:0]          coef_reg;
    logic signed [SW-1:0]                 cur_reg, cur_next;
    logic signed [PW-1:0]                 prod_reg, prod_next;
    logic signed [AW-1:0]                 part_reg, part_next;
    logic                                 out_valid_reg;
    logic signed [SW-1:0]                 out_data_reg;

    // Per-section history, one entry per notch section.
    logic signed [SW-1:0] x1_reg [NS];
    logic signed [SW-1:0] x2_reg [NS];
    logic signed [SW-1:0] y1_reg [NS];
    logic signed [SW-1:0] y2_reg [NS];

    // Tail history.
    logic signed [SW-1:0] avg_prev_reg;
    logic                 avg_primed_reg;
    logic signed [SW-1:0] hp_in_reg;
    logic signed [SW-1:0] hp_out_reg;

    // Control decoded from the state.
    logic in_xfer;
    logic do_mul;
    logic do_acc;
    logic out_load;
    logic last_stage;

    // Datapath intermediates.
    logic signed [SW-1:0]   hx1, hx2, hy1, hy2;
    logic signed [SW:0]     fwd_sum;
    logic signed [SW+2:0]   fwd_triple;
    logic signed [SW:0]     fb_diff;
    logic signed [AW-1:0]   acc_sum;
    logic signed [AW-1:0]   acc_shifted;
    logic signed [SW-1:0]   stage_out;
    logic signed [SW-1:0]   avg_base;
    logic signed [SW:0]     avg_sum;
    logic signed [SW-1:0]   avg_val;
    logic signed [SW:0]     hp_diff;
    logic signed [HW-1:0]   hp_sum;
    logic signed [HW-1:0]   hp_shifted;
    logic signed [SW-1:0]   hp_val;

    assign last_stage = (stage_reg == cnhc_pkg::STAGE_W'(NS - 1));

    // Next-state logic of the sequencer.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            cnhc_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = cnhc_pkg::ST_MUL;
                end
            end
            cnhc_pkg::ST_MUL: begin
                state_next = cnhc_pkg::ST_ACC;
            end
            cnhc_pkg::ST_ACC: begin
                if (last_stage) begin
                    state_next = cnhc_pkg::ST_TAIL;
                end else begin
                    state_next = cnhc_pkg::ST_MUL;
                end
            end
            cnhc_pkg::ST_TAIL: begin
                if (!out_valid_reg || m_ready) begin
                    state_next = cnhc_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = cnhc_pkg::ST_IDLE;
            end
        endcase
    end

    // Output decode of the sequencer.
    always_comb begin
        s_ready  = 1'b0;
        do_mul   = 1'b0;
        do_acc   = 1'b0;
        out_load = 1'b0;
        case (state_reg)
            cnhc_pkg::ST_IDLE: s_ready  = 1'b1;
            cnhc_pkg::ST_MUL:  do_mul   = 1'b1;
            cnhc_pkg::ST_ACC:  do_acc   = 1'b1;
            cnhc_pkg::ST_TAIL: out_load = !out_valid_reg || m_ready;
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    assign in_xfer = s_valid && s_ready;

    // History of the section being worked on.
    assign hx1 = x1_reg[stage_reg];
    assign hx2 = x2_reg[stage_reg];
    assign hy1 = y1_reg[stage_reg];
    assign hy2 = y2_reg[stage_reg];

    // Multiply cycle: k * (x1 - y1) on the shared multiplier, and the
    // feed-forward and second feedback terms as shifts and adds.
    always_comb begin
        fwd_sum    = {cur_reg[SW-1], cur_reg} + {hx2[SW-1], hx2};
        fwd_triple = {{2{fwd_sum[SW]}}, fwd_sum} + {fwd_sum[SW], fwd_sum, 1'b0};
        fb_diff    = {hx1[SW-1], hx1} - {hy1[SW-1], hy1};
        prod_next  = $signed({1'b0, coef_reg}) * fb_diff;
        part_next  = ({{(AW-SW-3){fwd_triple[SW+2]}}, fwd_triple} <<< cnhc_pkg::FF_SHIFT)
                   - ({{(AW-SW){hy2[SW-1]}}, hy2} <<< cnhc_pkg::FB_SHIFT);
    end

    // Accumulate cycle: sum, floor shift and saturate.
    always_comb begin
        acc_sum     = {{(AW-PW){prod_reg[PW-1]}}, prod_reg} + part_reg;
        acc_shifted = acc_sum >>> cnhc_pkg::FRAC_BITS;
        stage_out   = cnhc_pkg::sat_sample(acc_shifted);
    end

    // Tail: two-sample average, primed by the first sample, then high-pass.
    always_comb begin
        avg_base   = avg_primed_reg ? avg_prev_reg : cur_reg;
        avg_sum    = {cur_reg[SW-1], cur_reg} + {avg_base[SW-1], avg_base};
        avg_val    = avg_sum[SW:1];
        hp_diff    = {avg_val[SW-1], avg_val} - {hp_in_reg[SW-1], hp_in_reg};
        hp_sum     = ({{(HW-SW-1){hp_diff[SW]}}, hp_diff} <<< cnhc_pkg::HP_GAIN_SHIFT)
                   + {{(HW-SW){hp_out_reg[SW-1]}}, hp_out_reg};
        hp_shifted = hp_sum >>> cnhc_pkg::HP_OUT_SHIFT;
        hp_val     = cnhc_pkg::sat_sample({{(AW-HW){hp_shifted[HW-1]}}, hp_shifted});
    end

    // Next values of the working sample and the stage counter.
    always_comb begin
        cur_next   = cur_reg;
        stage_next = stage_reg;
        if (in_xfer) begin
            cur_next   = s_sample;
            stage_next = '0;
        end else if (do_acc) begin
            cur_next = stage_out;
            if (!last_stage) begin
                stage_next = stage_reg + 1'b1;
            end
        end
    end

    // Control registers and coefficient.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= cnhc_pkg::ST_IDLE;
            stage_reg     <= '0;
            coef_reg      <= cnhc_pkg::COEF_RESET;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            stage_reg <= stage_next;
            if (cfg_wr_en) begin
                coef_reg <= cfg_wr_data;
            end
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers of the datapath.
    always_ff @(posedge aclk) begin
        cur_reg <= cur_next;
        if (do_mul) begin
            prod_reg <= prod_next;
            part_reg <= part_next;
        end
        if (out_load) begin
            out_data_reg <= hp_val;
        end
    end

    // Filter history, cleared by reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NS; i++) begin
                x1_reg[i] <= '0;
                x2_reg[i] <= '0;
                y1_reg[i] <= '0;
                y2_reg[i] <= '0;
            end
            avg_prev_reg   <= '0;
            avg_primed_reg <= 1'b0;
            hp_in_reg      <= '0;
            hp_out_reg     <= '0;
        end else begin
            if (do_acc) begin
                x2_reg[stage_reg] <= hx1;
                x1_reg[stage_reg] <= cur_reg;
                y2_reg[stage_reg] <= hy1;
                y1_reg[stage_reg] <= stage_out;
            end
            if (out_load) begin
                avg_prev_reg   <= cur_reg;
                avg_primed_reg <= 1'b1;
                hp_in_reg      <= avg_val;
                hp_out_reg     <= hp_val;
            end
        end
    end

    assign m_valid    = out_valid_reg;
    assign m_filtered = out_data_reg;

    // A transfer always starts the first section.
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_xfer |=> (state_reg == cnhc_pkg::ST_MUL) && (stage_reg == '0))
        else $error("sample transfer did not start the first notch section");

    // The stage counter never leaves the range of sections while working.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == cnhc_pkg::ST_MUL || state_reg == cnhc_pkg::ST_ACC)
            |-> (stage_reg <= cnhc_pkg::STAGE_W'(NS - 1)))
        else $error("notch stage counter out of range");

    // Every multiply is followed by its accumulate.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == cnhc_pkg::ST_MUL) |=> (state_reg == cnhc_pkg::ST_ACC))
        else $error("multiply cycle not followed by accumulate");

    // A result only appears after the tail step.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> ($past(state_reg) == cnhc_pkg::ST_TAIL))
        else $error("result raised outside the tail step");

    // The tail is only reached after the last section.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == cnhc_pkg::ST_ACC) && !last_stage |=> (state_reg == cnhc_pkg::ST_MUL))
        else $error("notch cascade left early");

endmodule
